### design/qpd_pkg.sv
`default_nettype none

package qpd_pkg;

  // item kinds
  localparam logic [1:0] KIND_EDGE      = 2'd0;
  localparam logic [1:0] KIND_RECOMPUTE = 2'd1;
  localparam logic [1:0] KIND_CALIBRATE = 2'd2;

  // drive direction codes
  localparam logic [1:0] DIR_BRAKE = 2'd0;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_REV   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_GAIN    = 2'd0;
  localparam logic [1:0] REG_TARGET  = 2'd1;
  localparam logic [1:0] REG_ENABLE  = 2'd2;

  // reset values
  localparam logic [7:0]  GAIN_RESET     = 8'd4;
  localparam logic [15:0] POSITION_RESET = 16'd1;

  // duty scaling: gain*mag*255/768 == gain*mag*85/256, saturates from 772 up
  localparam logic [23:0] SAT_PRODUCT = 24'd772;
  localparam logic [6:0]  DUTY_SCALE  = 7'd85;
  localparam logic [7:0]  DUTY_MAX    = 8'd255;

  typedef enum logic [1:0] {
    STEP_BAD  = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // decode table, indexed by {previous sample, current sample}
  localparam step_t STEP_TABLE [16] = '{
    STEP_BAD,  STEP_DOWN, STEP_UP,   STEP_BAD,
    STEP_UP,   STEP_BAD,  STEP_BAD,  STEP_DOWN,
    STEP_DOWN, STEP_BAD,  STEP_BAD,  STEP_UP,
    STEP_BAD,  STEP_UP,   STEP_DOWN, STEP_BAD
  };

  // what the front part hands to the back part
  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  error_count;
  } q_item_t;

  function automatic step_t step_decode(input logic [1:0] prev, input logic [1:0] cur);
    return STEP_TABLE[{prev, cur}];
  endfunction

endpackage

`default_nettype wire

### design/qpd_queue.sv
`default_nettype none

module qpd_queue
  import qpd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t push_item,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output q_item_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/qpd_front.sv
`default_nettype none

module qpd_front
  import qpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [1:0] encoder_ab,
  input  wire logic       q_full,
  output logic            push,
  output q_item_t         push_item
);

  logic [15:0] position_cnt;
  logic [15:0] position_cnt_next;
  logic [7:0]  invalid_steps;
  logic [7:0]  invalid_steps_next;
  logic [1:0]  last_sample;
  logic [1:0]  last_sample_next;
  step_t       step;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign step = step_decode(last_sample, encoder_ab);

  // classify the item and update the counter state
  always_comb begin
    position_cnt_next  = position_cnt;
    invalid_steps_next = invalid_steps;
    last_sample_next   = last_sample;
    unique case (kind)
      KIND_EDGE: begin
        last_sample_next = encoder_ab;
        unique case (step)
          STEP_UP:   position_cnt_next = position_cnt + 16'd1;
          STEP_DOWN: position_cnt_next = position_cnt - 16'd1;
          default:   invalid_steps_next = invalid_steps + 8'd1;
        endcase
      end
      KIND_CALIBRATE: begin
        position_cnt_next = POSITION_RESET;
      end
      default: begin
        // recompute, and the unused code, leave the state alone
      end
    endcase
  end

  assign push_item.position    = position_cnt_next;
  assign push_item.error_count = invalid_steps_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_cnt  <= POSITION_RESET;
      invalid_steps <= '0;
      last_sample   <= '0;
    end else if (push) begin
      position_cnt  <= position_cnt_next;
      invalid_steps <= invalid_steps_next;
      last_sample   <= last_sample_next;
    end
  end

endmodule

`default_nettype wire

### design/qpd_back.sv
`default_nettype none

module qpd_back
  import qpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  gain,
  input  wire logic [15:0] target_position,
  input  wire logic        drive_enable,
  input  wire logic        q_empty,
  input  wire q_item_t     q_head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       direction,
  output logic [7:0]       pwm_duty,
  output logic [15:0]      position,
  output logic [7:0]       error_count
);

  logic        advance;
  logic [15:0] diff;
  logic        neg;
  logic [15:0] mag;

  // stage 1: error magnitude and direction
  logic        s1_valid;
  logic [15:0] s1_mag;
  logic        s1_gt1;
  logic [1:0]  s1_dir;
  q_item_t     s1_item;

  // stage 2: gain product
  logic        s2_valid;
  logic [23:0] s2_prod;
  logic        s2_gt1;
  logic [1:0]  s2_dir;
  q_item_t     s2_item;

  logic [16:0] scaled;
  logic [7:0]  duty;

  // the whole chain moves unless the output register is held
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_empty;

  assign diff = q_head.position - target_position;
  assign neg  = diff[15];
  assign mag  = neg ? (~diff + 16'd1) : diff;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mag  <= mag;
      s1_gt1  <= (mag > 16'd1);
      s1_item <= q_head;
      if (drive_enable && (mag != 16'd0)) begin
        s1_dir <= neg ? DIR_REV : DIR_FWD;
      end else begin
        s1_dir <= DIR_BRAKE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod <= 24'(gain) * 24'(s1_mag);
      s2_gt1  <= s1_gt1;
      s2_dir  <= s1_dir;
      s2_item <= s1_item;
    end
  end

  // duty: 0 on brake or mag<=1, saturated, else prod*85/256
  assign scaled = 17'(s2_prod[9:0]) * 17'(DUTY_SCALE);

  always_comb begin
    priority if (s2_dir == DIR_BRAKE || !s2_gt1) begin
      duty = '0;
    end else if (s2_prod >= SAT_PRODUCT) begin
      duty = DUTY_MAX;
    end else begin
      duty = scaled[15:8];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      direction   <= s2_dir;
      pwm_duty    <= duty;
      position    <= s2_item.position;
      error_count <= s2_item.error_count;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

### design/quadrature_position_p_drive.sv
// Quadrature position decoder with a proportional position drive.
// Input channel (in_valid / in_stall): kind and encoder_ab. An edge sample
// steps the 16-bit position or bumps the error count, a calibrate sets the
// position to 1, a recompute leaves the state alone. Every item gives one
// result on the output channel (out_valid / out_stall): direction, pwm_duty,
// position and error_count after that item.
// Configuration: wr_en, wr_index (0 gain, 1 target_position, 2 drive_enable)
// and wr_data; the user must see they are written only while no item is in
// flight, which the block itself does not enforce. From input transfer to
// result valid: counter update and queue write at the transfer, then the
// magnitude stage, multiply stage and output register. Throughput is one
// item per cycle while the queue is not full.
// The queue between the front and the back holds QUEUE_DEPTH items; when it
// is full in_stall rises. A stall on the output holds the result and the
// whole back pipeline; the front keeps taking items until the queue fills.
// Reset (rst, synchronous): position 1, error count 0, last sample 0,
// gain 4, target 0, drive disabled, queue and pipeline empty.
`default_nettype none

module quadrature_position_p_drive
  import qpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [1:0]  encoder_ab,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       direction,
  output logic [7:0]       pwm_duty,
  output logic [15:0]      position,
  output logic [7:0]       error_count,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data
);

  logic [7:0]  gain;
  logic [15:0] target_position;
  logic        drive_enable;

  logic        q_push;
  q_item_t     q_push_item;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  q_item_t     q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RESET;
      target_position <= '0;
      drive_enable    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAIN:   gain            <= wr_data[7:0];
        REG_TARGET: target_position <= wr_data;
        REG_ENABLE: drive_enable    <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  qpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .encoder_ab (encoder_ab),
    .q_full     (q_full),
    .push       (q_push),
    .push_item  (q_push_item)
  );

  qpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  qpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .gain            (gain),
    .target_position (target_position),
    .drive_enable    (drive_enable),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .direction       (direction),
    .pwm_duty        (pwm_duty),
    .position        (position),
    .error_count     (error_count)
  );

  // a nonzero duty always comes with a drive direction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (pwm_duty != 8'd0) |-> (direction != DIR_BRAKE))
    else $error("nonzero duty with brake direction");

  // a disabled drive always brakes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_enable |-> (direction == DIR_BRAKE) && (pwm_duty == 8'd0))
    else $error("drive active while disabled");

  // nothing is valid right after reset
  assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && q_empty)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import qpd_pkg::*;

  // spare kind code, handled like a recompute
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int MAX_WAIT = 6;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] ab;
  } sample_t;

  typedef struct packed {
    logic [1:0]  dir;
    logic [7:0]  duty;
    logic [15:0] pos;
    logic [7:0]  errs;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_RECOMPUTE;
  logic [1:0]  encoder_ab = 2'b00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  direction;
  logic [7:0]  pwm_duty;
  logic [15:0] position;
  logic [7:0]  error_count;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_GAIN;
  logic [15:0] wr_data = '0;

  quadrature_position_p_drive i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .encoder_ab  (encoder_ab),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .direction   (direction),
    .pwm_duty    (pwm_duty),
    .position    (position),
    .error_count (error_count),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data)
  );

  always #5 clk = ~clk;

  // drive settings and decoder state as the block should hold them
  logic [7:0]  cfg_gain = GAIN_RESET;
  logic [15:0] cfg_target = '0;
  logic        cfg_enable = 1'b0;
  logic [15:0] pos_count = POSITION_RESET;
  logic [7:0]  bad_steps = '0;
  logic [1:0]  prev_ab = 2'b00;

  sample_t pending_samples[$];
  drive_t  expected_drives[$];
  bit      holding = 1'b0;
  bit      hold_sender = 1'b0;
  bit      no_gaps = 1'b0;
  bit      no_stalls = 1'b0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  logic [1:0] gen_ab = 2'b00;
  bit      gen_up = 1'b1;

  // gray code step between two encoder samples
  function automatic step_t decode_step(logic [1:0] prev, logic [1:0] cur);
    case ({prev, cur})
      4'b0100, 4'b1101, 4'b0010, 4'b1011: return STEP_UP;
      4'b1000, 4'b0001, 4'b1110, 4'b0111: return STEP_DOWN;
      default: return STEP_BAD;
    endcase
  endfunction

  // update decoder state for one item and work out the drive it gives
  function automatic drive_t predict_drive(sample_t s);
    step_t       st;
    logic [15:0] diff;
    logic [16:0] mag;
    logic [31:0] prod;
    drive_t      d;
    if (s.kind == KIND_EDGE) begin
      st = decode_step(prev_ab, s.ab);
      if (st == STEP_UP)
        pos_count = pos_count + 16'd1;
      else if (st == STEP_DOWN)
        pos_count = pos_count - 16'd1;
      else
        bad_steps = bad_steps + 8'd1;
      prev_ab = s.ab;
    end else if (s.kind == KIND_CALIBRATE) begin
      pos_count = POSITION_RESET;
    end
    diff = pos_count - cfg_target;
    mag = diff[15] ? 17'h10000 - {1'b0, diff} : {1'b0, diff};
    d.dir = DIR_BRAKE;
    d.duty = '0;
    if (cfg_enable && mag != 17'd0) begin
      d.dir = diff[15] ? DIR_REV : DIR_FWD;
      if (mag > 17'd1) begin
        prod = (32'(cfg_gain) * 32'(mag) * 32'd255) / 32'd768;
        d.duty = (prod > 32'd255) ? 8'd255 : prod[7:0];
      end
    end
    d.pos = pos_count;
    d.errs = bad_steps;
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // input driver: one transfer per pending sample, random gap between them
  always @(posedge clk) begin
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_drives.push_back(predict_drive({kind, encoder_ab}));
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0 && !hold_sender) begin
          nxt = pending_samples.pop_front();
          kind <= nxt.kind;
          encoder_ab <= nxt.ab;
          in_valid <= 1'b1;
          holding = 1'b1;
          gap_left = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transfer with the oldest expected drive
  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          report_mismatch("result with no expected drive");
        end else begin
          want = expected_drives.pop_front();
          check_field("direction", 16'(direction), 16'(want.dir));
          check_field("pwm_duty", 16'(pwm_duty), 16'(want.duty));
          check_field("position", position, want.pos);
          check_field("error_count", 16'(error_count), 16'(want.errs));
        end
        stall_left = no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_GAIN:   cfg_gain = val[7:0];
      REG_TARGET: cfg_target = val;
      REG_ENABLE: cfg_enable = val[0];
      default: ;
    endcase
  endtask

  // wait until every queued sample has been sent and answered
  task automatic wait_drained();
    while (pending_samples.size() != 0 || holding || expected_drives.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic push_sample(logic [1:0] k, logic [1:0] ab);
    pending_samples.push_back({k, ab});
    if (k == KIND_EDGE)
      gen_ab = ab;
  endtask

  // next sample one valid step up or down the gray sequence
  function automatic logic [1:0] gray_step(logic [1:0] ab, bit up);
    case (ab)
      2'b00:   return up ? 2'b10 : 2'b01;
      2'b10:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b01 : 2'b10;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // step_pct% valid steps, bad_pct% invalid samples, the rest other kinds
  task automatic push_random_item(int step_pct, int bad_pct);
    int r;
    int other;
    r = $urandom_range(0, 99);
    other = $urandom_range(0, 9);
    if (r < step_pct) begin
      if ($urandom_range(0, 7) == 0)
        gen_up = ~gen_up;
      push_sample(KIND_EDGE, gray_step(gen_ab, gen_up));
    end else if (r < step_pct + bad_pct) begin
      push_sample(KIND_EDGE, $urandom_range(0, 1) ? gen_ab : ~gen_ab);
    end else if (other < 5) begin
      push_sample(KIND_RECOMPUTE, 2'($urandom_range(0, 3)));
    end else if (other < 8) begin
      push_sample(KIND_CALIBRATE, 2'($urandom_range(0, 3)));
    end else begin
      push_sample(KIND_SPARE, 2'($urandom_range(0, 3)));
    end
  endtask

  // new drive settings, target near the current position half the time
  task automatic set_random_config();
    logic [7:0]  g;
    logic [15:0] tgt;
    case ($urandom_range(0, 5))
      0:       g = 8'd0;
      1:       g = 8'd255;
      2:       g = 8'd1;
      default: g = 8'($urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       tgt = 16'($urandom_range(0, 65535));
      1:       tgt = pos_count ^ 16'h8000;
      2:       tgt = ($urandom_range(0, 1)) ? 16'h0000 : 16'hFFFF;
      default: tgt = pos_count + 16'($urandom_range(0, 60)) - 16'd30;
    endcase
    write_reg(REG_GAIN, {8'd0, g});
    write_reg(REG_TARGET, tgt);
    write_reg(REG_ENABLE, {15'd0, ($urandom_range(0, 4) != 0)});
  endtask

  // reset and stimulus
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: drive disabled
    push_sample(KIND_RECOMPUTE, 2'b00);
    wait_drained();
    write_reg(REG_GAIN, 16'd4);
    write_reg(REG_TARGET, 16'd0);
    write_reg(REG_ENABLE, 16'd1);

    // error of one, full cycles up and down, invalid samples, wrap through zero
    push_sample(KIND_RECOMPUTE, 2'b11);
    push_sample(KIND_EDGE, 2'b10);
    push_sample(KIND_EDGE, 2'b11);
    push_sample(KIND_EDGE, 2'b01);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b01);
    push_sample(KIND_EDGE, 2'b11);
    push_sample(KIND_EDGE, 2'b10);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b11);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b01);
    push_sample(KIND_EDGE, 2'b10);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b01);
    push_sample(KIND_EDGE, 2'b00);
    push_sample(KIND_EDGE, 2'b10);
    push_sample(KIND_CALIBRATE, 2'b11);
    push_sample(KIND_SPARE, 2'b10);
    wait_drained();

    // most negative error, full gain then zero gain
    write_reg(REG_GAIN, 16'd255);
    write_reg(REG_TARGET, 16'h8001);
    push_sample(KIND_RECOMPUTE, 2'b01);
    wait_drained();
    write_reg(REG_GAIN, 16'd0);
    push_sample(KIND_RECOMPUTE, 2'b10);
    wait_drained();

    // small and most positive error across the wrap, then drive disabled
    write_reg(REG_GAIN, 16'd255);
    write_reg(REG_TARGET, 16'hFFFF);
    push_sample(KIND_RECOMPUTE, 2'b00);
    wait_drained();
    write_reg(REG_TARGET, 16'h8002);
    push_sample(KIND_RECOMPUTE, 2'b11);
    wait_drained();
    write_reg(REG_ENABLE, 16'd0);
    push_sample(KIND_RECOMPUTE, 2'b01);
    wait_drained();

    // random phases, one noisy enough to wrap the error count
    for (int phase = 0; phase < 7; phase++) begin
      set_random_config();
      no_gaps = (phase == 1) || ($urandom_range(0, 3) == 0);
      no_stalls = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 5) begin
        for (int i = 0; i < 280; i++)
          push_random_item(15, 80);
      end else if (phase == 3) begin
        for (int i = 0; i < 35; i++)
          push_random_item(78, 10);
        while (pending_samples.size() > 15)
          @(posedge clk);
        hold_sender = 1'b1;
        while (holding || expected_drives.size() != 0)
          @(posedge clk);
        hold_sender = 1'b0;
        for (int i = 0; i < 35; i++)
          push_random_item(78, 10);
      end else begin
        for (int i = 0; i < 70; i++)
          push_random_item(78, 10);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** quadrature_position_p_drive: PASSED **");
    else
      $display("** quadrature_position_p_drive: FAILED **");
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("** quadrature_position_p_drive: FAILED **");
    $finish;
  end

endmodule
